/* src/slci_pkg.sv */
// Package for the serial LCD command interface.
// Holds the phase type, the state and response records and the sync constants.
// Used by slci_step and serial_lcd_command_interface.
package slci_pkg;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_BUSY_TX = 4'd1,
      PH_BUSY_R1 = 4'd2,
      PH_BUSY_R2 = 4'd3,
      PH_SYNC_TX = 4'd4,
      PH_HI_TX   = 4'd5,
      PH_LO_TX   = 4'd6,
      PH_RD_R1   = 4'd7,
      PH_RD_R2   = 4'd8
   } phase_type;

   localparam logic [1:0] REQ_WR_CMD  = 2'd0;
   localparam logic [1:0] REQ_WR_DATA = 2'd1;
   localparam logic [1:0] REQ_RD_DATA = 2'd2;

   localparam logic [7:0] SYNC_WR_CMD  = 8'hF8;
   localparam logic [7:0] SYNC_WR_DATA = 8'hFA;
   localparam logic [7:0] SYNC_BUSY    = 8'hFC;
   localparam logic [7:0] SYNC_RD_DATA = 8'hFE;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] bit_count;
      logic       half_bit;
      logic [7:0] shift_reg;
      logic [7:0] first_rx_byte;
      logic [1:0] pending_kind;
      logic [7:0] pending_byte;
   } state_type;

   typedef struct packed {
      logic       chip_select;
      logic       serial_clock;
      logic       serial_data_out;
      logic       data_drive;
      logic       ready_res;
      logic       read_valid;
      logic [7:0] read_byte;
   } rsp_type;

   function automatic logic [7:0] sync_byte(input logic [1:0] kind);
      logic [7:0] result;
      unique case (kind)
         REQ_WR_CMD:  result = SYNC_WR_CMD;
         REQ_WR_DATA: result = SYNC_WR_DATA;
         default:     result = SYNC_RD_DATA;
      endcase
      return result;
   endfunction

endpackage

/* src/serial_lcd_command_interface.sv */
// Serial LCD command interface: tick-driven three-wire master for a character display.
// Top level; instantiates slci_step and uses slci_pkg.
//
// Usage: every request on the req_ channel is one clock tick of the serial
// sequence and carries the command fields (req_req_valid, req_req_type,
// req_req_byte) together with the sampled data line level req_sid_in.
// For each accepted request exactly one response leaves on the rsp_ channel,
// holding the pin levels for that tick plus ready_res, read_valid and read_byte.
// A command offered while a transaction is running is dropped.
// The response is registered; rsp_valid rises in the cycle after acceptance when
// the output is free. Throughput is one request per cycle while req_stall is low;
// the per-tick state update is a single pass of logic between the state register
// and the response register. A two-entry output buffer (response register plus skid
// register) lets a request be taken while a response still waits; req_stall rises
// only when both entries are full, so the skid entry absorbs a request during a stall.
// Reset returns the sequencer to idle, clears both buffer entries and drops
// req_stall; responses held at reset are discarded.
module serial_lcd_command_interface (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_req_valid,
   input  logic [1:0] req_req_type,
   input  logic [7:0] req_req_byte,
   input  logic       req_sid_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_chip_select,
   output logic       rsp_serial_clock,
   output logic       rsp_serial_data_out,
   output logic       rsp_data_drive,
   output logic       rsp_ready_res,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte
);
   import slci_pkg::*;

   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;
   rsp_type   out_ff;
   rsp_type   out_in;
   rsp_type   skid_ff;
   rsp_type   skid_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   state_type step_state;
   logic      req_take;
   logic      rsp_take;

   slci_step u_step (
      .cur_state (state_ff),
      .req_flag  (req_req_valid),
      .req_type  (req_req_type),
      .req_byte  (req_req_byte),
      .sid_in    (req_sid_in),
      .nxt_state (step_state),
      .rsp       (step_rsp)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      state_in      = req_take ? step_state : state_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_rsp;
            out_valid_in = req_take;
         end
      end else if (req_take) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_chip_select     = out_ff.chip_select;
   assign rsp_serial_clock    = out_ff.serial_clock;
   assign rsp_serial_data_out = out_ff.serial_data_out;
   assign rsp_data_drive      = out_ff.data_drive;
   assign rsp_ready_res       = out_ff.ready_res;
   assign rsp_read_valid      = out_ff.read_valid;
   assign rsp_read_byte       = out_ff.read_byte;

endmodule

/* src/slci_step.sv */
// One tick of the serial LCD master: next state and pin levels from the current state.
// Purely combinational; depends on slci_pkg.
module slci_step (
   input  slci_pkg::state_type cur_state,
   input  logic                req_flag,
   input  logic [1:0]          req_type,
   input  logic [7:0]          req_byte,
   input  logic                sid_in,
   output slci_pkg::state_type nxt_state,
   output slci_pkg::rsp_type   rsp
);
   import slci_pkg::*;

   logic [7:0] rx_byte;
   logic [7:0] rx_comb;

   assign rx_byte = {cur_state.shift_reg[6:0], sid_in};
   assign rx_comb = {cur_state.first_rx_byte[7:4], rx_byte[3:0]};

   always_comb begin
      nxt_state = cur_state;
      rsp       = '0;
      unique case (cur_state.phase)
         PH_BUSY_TX, PH_SYNC_TX, PH_HI_TX, PH_LO_TX: begin
            rsp.chip_select     = 1'b1;
            rsp.data_drive      = 1'b1;
            rsp.serial_data_out = cur_state.shift_reg[7];
            rsp.serial_clock    = cur_state.half_bit;
            if (!cur_state.half_bit) begin
               nxt_state.half_bit = 1'b1;
            end else begin
               nxt_state.half_bit  = 1'b0;
               nxt_state.shift_reg = {cur_state.shift_reg[6:0], 1'b0};
               if (cur_state.bit_count == LAST_BIT) begin
                  nxt_state.bit_count = '0;
                  unique case (cur_state.phase)
                     PH_BUSY_TX: begin
                        nxt_state.phase     = PH_BUSY_R1;
                        nxt_state.shift_reg = '0;
                     end
                     PH_SYNC_TX: begin
                        if (cur_state.pending_kind == REQ_RD_DATA) begin
                           nxt_state.phase     = PH_RD_R1;
                           nxt_state.shift_reg = '0;
                        end else begin
                           nxt_state.phase     = PH_HI_TX;
                           nxt_state.shift_reg = {cur_state.pending_byte[7:4], 4'h0};
                        end
                     end
                     PH_HI_TX: begin
                        nxt_state.phase     = PH_LO_TX;
                        nxt_state.shift_reg = {cur_state.pending_byte[3:0], 4'h0};
                     end
                     default: begin
                        nxt_state.phase     = PH_IDLE;
                        nxt_state.shift_reg = '0;
                     end
                  endcase
               end else begin
                  nxt_state.bit_count = cur_state.bit_count + 3'd1;
               end
            end
         end
         PH_BUSY_R1, PH_BUSY_R2, PH_RD_R1, PH_RD_R2: begin
            rsp.chip_select  = 1'b1;
            rsp.serial_clock = ~cur_state.half_bit;
            if (!cur_state.half_bit) begin
               nxt_state.half_bit = 1'b1;
            end else begin
               nxt_state.half_bit  = 1'b0;
               nxt_state.shift_reg = rx_byte;
               if (cur_state.bit_count == LAST_BIT) begin
                  nxt_state.bit_count = '0;
                  unique case (cur_state.phase)
                     PH_BUSY_R1: begin
                        nxt_state.first_rx_byte = rx_byte;
                        nxt_state.phase         = PH_BUSY_R2;
                        nxt_state.shift_reg     = '0;
                     end
                     PH_RD_R1: begin
                        nxt_state.first_rx_byte = rx_byte;
                        nxt_state.phase         = PH_RD_R2;
                        nxt_state.shift_reg     = '0;
                     end
                     PH_BUSY_R2: begin
                        if (rx_comb[7]) begin
                           nxt_state.phase     = PH_BUSY_TX;
                           nxt_state.shift_reg = SYNC_BUSY;
                        end else begin
                           nxt_state.phase     = PH_SYNC_TX;
                           nxt_state.shift_reg = sync_byte(cur_state.pending_kind);
                        end
                     end
                     default: begin
                        rsp.read_valid      = 1'b1;
                        rsp.read_byte       = rx_comb;
                        nxt_state.phase     = PH_IDLE;
                        nxt_state.shift_reg = '0;
                     end
                  endcase
               end else begin
                  nxt_state.bit_count = cur_state.bit_count + 3'd1;
               end
            end
         end
         default: begin
            nxt_state.phase = PH_IDLE;
            if (req_flag && (req_type == REQ_WR_CMD || req_type == REQ_WR_DATA ||
                             req_type == REQ_RD_DATA)) begin
               rsp.ready_res          = 1'b1;
               nxt_state.pending_kind = req_type;
               nxt_state.pending_byte = req_byte;
               nxt_state.phase        = PH_BUSY_TX;
               nxt_state.shift_reg    = SYNC_BUSY;
               nxt_state.bit_count    = '0;
               nxt_state.half_bit     = 1'b0;
            end
         end
      endcase
   end

endmodule

/* src/slci_checker.sv */
// Port-level checks for the serial LCD command interface.
// Bound to serial_lcd_command_interface; needs no package.
module slci_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_chip_select,
   input logic       rsp_serial_clock,
   input logic       rsp_serial_data_out,
   input logic       rsp_data_drive,
   input logic       rsp_ready_res,
   input logic       rsp_read_valid,
   input logic [7:0] rsp_read_byte
);

   // A stalled response must hold its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte) &&
         $stable(rsp_chip_select) && $stable(rsp_read_valid))
      else $error("stalled response changed");

   // After reset nothing is pending and requests are welcome.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("buffer not empty after reset");

   // With chip select low the serial pins stay quiet.
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chip_select |-> !rsp_serial_clock && !rsp_serial_data_out &&
         !rsp_data_drive)
      else $error("pins active while deselected");

   // A completed read happens in a receive tick, never in an idle one.
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_chip_select && !rsp_data_drive &&
         !rsp_ready_res)
      else $error("read completion outside a receive tick");

   // A new request is only taken while the bus is idle.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready_res |-> !rsp_chip_select && !rsp_read_valid)
      else $error("request taken during a transaction");

endmodule

bind serial_lcd_command_interface slci_checker u_slci_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for serial_lcd_command_interface.
// Drives pin-level ticks, predicts each tick's response in place and checks it.
// Depends on slci_pkg and the serial_lcd_command_interface RTL.
module tb_top;
   import slci_pkg::*;

   localparam logic [1:0] REQ_TYPE_NONE = 2'd3;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_req_valid = 1'b0;
   logic [1:0] req_req_type = '0;
   logic [7:0] req_req_byte = '0;
   logic       req_sid_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_chip_select;
   logic       rsp_serial_clock;
   logic       rsp_serial_data_out;
   logic       rsp_data_drive;
   logic       rsp_ready_res;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_byte;

   phase_type  cur_phase = PH_IDLE;
   logic [2:0] bit_idx = '0;
   logic       half_tick = 1'b0;
   logic [7:0] shreg = '0;
   logic [7:0] first_byte = '0;
   logic [1:0] held_kind = '0;
   logic [7:0] held_byte = '0;

   rsp_type expected_pins[$];
   int fail_count = 0;
   int ticks_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int busy_pct = 0;
   int hold_len = 0;
   int hold_left = 0;

   serial_lcd_command_interface u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_req_valid(req_req_valid),
      .req_req_type(req_req_type),
      .req_req_byte(req_req_byte),
      .req_sid_in(req_sid_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_chip_select(rsp_chip_select),
      .rsp_serial_clock(rsp_serial_clock),
      .rsp_serial_data_out(rsp_serial_data_out),
      .rsp_data_drive(rsp_data_drive),
      .rsp_ready_res(rsp_ready_res),
      .rsp_read_valid(rsp_read_valid),
      .rsp_read_byte(rsp_read_byte)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void enter_phase(input phase_type p, input logic [7:0] fill);
      cur_phase = p;
      shreg = fill;
      bit_idx = '0;
      half_tick = 1'b0;
   endfunction

   function automatic rsp_type predict_pins(input logic v, input logic [1:0] t,
                                            input logic [7:0] b, input logic s);
      rsp_type r;
      logic [7:0] merged;
      r = '0;
      case (cur_phase)
         PH_BUSY_TX, PH_SYNC_TX, PH_HI_TX, PH_LO_TX: begin
            r.chip_select = 1'b1;
            r.data_drive = 1'b1;
            r.serial_data_out = shreg[7];
            r.serial_clock = half_tick;
            if (!half_tick) begin
               half_tick = 1'b1;
            end else begin
               half_tick = 1'b0;
               shreg = {shreg[6:0], 1'b0};
               if (bit_idx == LAST_BIT) begin
                  case (cur_phase)
                     PH_BUSY_TX: enter_phase(PH_BUSY_R1, 8'h00);
                     PH_SYNC_TX: begin
                        if (held_kind == REQ_RD_DATA) enter_phase(PH_RD_R1, 8'h00);
                        else enter_phase(PH_HI_TX, {held_byte[7:4], 4'h0});
                     end
                     PH_HI_TX: enter_phase(PH_LO_TX, {held_byte[3:0], 4'h0});
                     default: enter_phase(PH_IDLE, 8'h00);
                  endcase
               end else begin
                  bit_idx++;
               end
            end
         end
         PH_BUSY_R1, PH_BUSY_R2, PH_RD_R1, PH_RD_R2: begin
            r.chip_select = 1'b1;
            r.serial_clock = ~half_tick;
            if (!half_tick) begin
               half_tick = 1'b1;
            end else begin
               half_tick = 1'b0;
               shreg = {shreg[6:0], s};
               if (bit_idx == LAST_BIT) begin
                  merged = {first_byte[7:4], shreg[3:0]};
                  case (cur_phase)
                     PH_BUSY_R1: begin
                        first_byte = shreg;
                        enter_phase(PH_BUSY_R2, 8'h00);
                     end
                     PH_RD_R1: begin
                        first_byte = shreg;
                        enter_phase(PH_RD_R2, 8'h00);
                     end
                     PH_BUSY_R2: begin
                        if (merged[7]) enter_phase(PH_BUSY_TX, SYNC_BUSY);
                        else if (held_kind == REQ_WR_CMD) enter_phase(PH_SYNC_TX, SYNC_WR_CMD);
                        else if (held_kind == REQ_WR_DATA) enter_phase(PH_SYNC_TX, SYNC_WR_DATA);
                        else enter_phase(PH_SYNC_TX, SYNC_RD_DATA);
                     end
                     default: begin
                        r.read_valid = 1'b1;
                        r.read_byte = merged;
                        enter_phase(PH_IDLE, 8'h00);
                     end
                  endcase
               end else begin
                  bit_idx++;
               end
            end
         end
         default: begin
            cur_phase = PH_IDLE;
            if (v && t != REQ_TYPE_NONE) begin
               r.ready_res = 1'b1;
               held_kind = t;
               held_byte = b;
               enter_phase(PH_BUSY_TX, SYNC_BUSY);
            end
         end
      endcase
      return r;
   endfunction

   // The display answers busy on the first bit of a poll with probability busy_pct.
   function automatic logic display_level();
      if (cur_phase == PH_BUSY_R1 && bit_idx == 3'd0) return $urandom_range(99) < busy_pct;
      return 1'($urandom_range(1));
   endfunction

   task automatic send_tick(input logic v, input logic [1:0] t, input logic [7:0] b,
                            input logic s);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_req_valid <= v;
      req_req_type <= t;
      req_req_byte <= b;
      req_sid_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pins.push_back(predict_pins(v, t, b, s));
      ticks_sent++;
   endtask

   task automatic finish_transaction();
      while (cur_phase != PH_IDLE) begin
         send_tick(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                   display_level());
      end
   endtask

   task automatic run_request(input logic [1:0] kind, input logic [7:0] data);
      send_tick(1'b1, kind, data, 1'($urandom_range(1)));
      finish_transaction();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_pins();
      rsp_type want;
      if (expected_pins.size() == 0) begin
         $display("%0t: response with no request pending, expected none, actual %0h", $time,
                  {rsp_chip_select, rsp_serial_clock, rsp_serial_data_out, rsp_data_drive,
                   rsp_ready_res, rsp_read_valid, rsp_read_byte});
         fail_count++;
      end else begin
         want = expected_pins.pop_front();
         check_field("chip_select", 8'(want.chip_select), 8'(rsp_chip_select));
         check_field("serial_clock", 8'(want.serial_clock), 8'(rsp_serial_clock));
         check_field("serial_data_out", 8'(want.serial_data_out), 8'(rsp_serial_data_out));
         check_field("data_drive", 8'(want.data_drive), 8'(rsp_data_drive));
         check_field("ready_res", 8'(want.ready_res), 8'(rsp_ready_res));
         check_field("read_valid", 8'(want.read_valid), 8'(rsp_read_valid));
         check_field("read_byte", want.read_byte, rsp_read_byte);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_pins();
   end

   always @(negedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic test_idle_and_ignored();
      send_tick(1'b0, REQ_WR_CMD, 8'hFF, 1'b1);
      send_tick(1'b0, REQ_RD_DATA, 8'h00, 1'b0);
      send_tick(1'b1, REQ_TYPE_NONE, 8'hFF, 1'b1);
      send_tick(1'b1, REQ_TYPE_NONE, 8'h00, 1'b0);
   endtask

   task automatic test_write_command();
      run_request(REQ_WR_CMD, 8'h00);
      run_request(REQ_WR_CMD, 8'hFF);
   endtask

   task automatic test_write_data();
      run_request(REQ_WR_DATA, 8'hA5);
      run_request(REQ_WR_DATA, 8'h5A);
   endtask

   task automatic test_read_data();
      run_request(REQ_RD_DATA, 8'h00);
      run_request(REQ_RD_DATA, 8'hFF);
   endtask

   task automatic test_busy_forever();
      send_tick(1'b1, REQ_WR_DATA, 8'h3C, 1'b0);
      busy_pct = 100;
      repeat (240) begin
         send_tick(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                   display_level());
      end
      busy_pct = 0;
      finish_transaction();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_len = 80;
      run_request(REQ_RD_DATA, 8'($urandom_range(255)));
      run_request(REQ_WR_CMD, 8'($urandom_range(255)));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int ticks);
      int target;
      int pick;
      target = ticks_sent + ticks;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      busy_pct = 25;
      while (ticks_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            run_request(2'($urandom_range(2)), 8'($urandom_range(255)));
         end else begin
            send_tick(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
            finish_transaction();
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_and_ignored();
      test_write_command();
      test_write_data();
      test_read_data();
      test_busy_forever();
      wait_drained();
      test_backpressure();
      test_random_traffic(33, 87, 230);
      test_random_traffic(87, 33, 230);
      test_random_traffic(0, 0, 230);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_pins.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
